// ===== design/mtrb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mtrb_pkg
// Shared types, constants and the crc helper for the tcp to rtu bridge.
// ---------------------------------------------------------------------------
package mtrb_pkg;

  localparam int MAX_LENGTH_DEF = 254;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // result index of the final result of a frame-end burst
  localparam logic [2:0] BURST_LAST = 3'd4;

  typedef enum logic [3:0] {
    PH_TID1 = 4'd0,
    PH_TID2 = 4'd1,
    PH_PID1 = 4'd2,
    PH_PID2 = 4'd3,
    PH_LEN1 = 4'd4,
    PH_LEN2 = 4'd5,
    PH_UNIT = 4'd6,
    PH_FUNC = 4'd7,
    PH_DATA = 4'd8,
    PH_WAIT = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    OK_SERIAL = 2'd0,
    OK_START  = 2'd1,
    OK_ARM    = 2'd2,
    OK_ABORT  = 2'd3
  } out_kind_t;

  typedef enum logic [1:0] {
    OP_FWD     = 2'd0,
    OP_FWD_END = 2'd1,
    OP_ARM     = 2'd2,
    OP_ABORT   = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic [15:0] crc;
  } cmd_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/mtrb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mtrb_front
// Mbap header parser: tracks the frame phase, runs the crc and queues one
// command per transaction that produces results.
// ---------------------------------------------------------------------------
module mtrb_front #(
  parameter int MAX_LENGTH = mtrb_pkg::MAX_LENGTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          in_kind,
  input  wire logic [7:0]    in_rx_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output mtrb_pkg::cmd_t     q_cmd
);
  import mtrb_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  length_high_r, length_high_nxt;
  logic [7:0]  frame_length_r, frame_length_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        proto_bad_r, proto_bad_nxt;

  logic        accept;
  logic [7:0]  count_inc;
  logic [15:0] crc_upd;
  logic        frame_end;
  logic        len_bad;
  logic        produce;
  op_t         op;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign count_inc = count_r + 8'd1;
  assign crc_upd   = crc16_byte(crc_r, in_rx_byte);
  assign frame_end = (count_inc >= frame_length_r);
  assign len_bad   = (length_high_r != 8'd0) || (in_rx_byte < 8'd2) ||
                     (in_rx_byte > 8'(MAX_LENGTH));

  // next state
  always_comb begin
    phase_nxt        = phase_r;
    length_high_nxt  = length_high_r;
    frame_length_nxt = frame_length_r;
    count_nxt        = count_r;
    crc_nxt          = crc_r;
    proto_bad_nxt    = proto_bad_r;
    if (accept) begin
      if (in_kind) begin
        phase_nxt     = PH_TID1;
        count_nxt     = 8'd0;
        crc_nxt       = CRC_INIT;
        proto_bad_nxt = 1'b0;
      end else begin
        case (phase_r)
          PH_TID2: phase_nxt = PH_PID1;
          PH_PID1: begin
            proto_bad_nxt = (in_rx_byte != 8'd0);
            phase_nxt     = PH_PID2;
          end
          PH_PID2: begin
            if (proto_bad_r || (in_rx_byte != 8'd0)) begin
              phase_nxt     = PH_TID1;
              count_nxt     = 8'd0;
              crc_nxt       = CRC_INIT;
              proto_bad_nxt = 1'b0;
            end else begin
              phase_nxt = PH_LEN1;
            end
          end
          PH_LEN1: begin
            length_high_nxt = in_rx_byte;
            phase_nxt       = PH_LEN2;
          end
          PH_LEN2: begin
            phase_nxt     = len_bad ? PH_TID1 : PH_UNIT;
            count_nxt     = 8'd0;
            crc_nxt       = CRC_INIT;
            proto_bad_nxt = len_bad ? 1'b0 : proto_bad_r;
            if (!len_bad) begin
              frame_length_nxt = in_rx_byte;
            end
          end
          PH_UNIT, PH_FUNC, PH_DATA: begin
            crc_nxt   = crc_upd;
            count_nxt = count_inc;
            if (frame_end) begin
              phase_nxt = PH_WAIT;
            end else if (phase_r == PH_UNIT) begin
              phase_nxt = PH_FUNC;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
          PH_WAIT: phase_nxt = PH_WAIT;
          default: phase_nxt = PH_TID2;
        endcase
      end
    end
  end

  // command outputs
  always_comb begin
    produce = 1'b0;
    op      = OP_FWD;
    if (in_kind) begin
      case (phase_r)
        PH_TID2, PH_PID1, PH_PID2, PH_LEN1, PH_LEN2, PH_UNIT, PH_FUNC, PH_DATA: begin
          produce = 1'b1;
          op      = OP_ABORT;
        end
        default: produce = 1'b0;
      endcase
    end else begin
      case (phase_r)
        PH_UNIT, PH_FUNC, PH_DATA: begin
          produce = 1'b1;
          op      = frame_end ? OP_FWD_END : OP_FWD;
        end
        PH_WAIT: begin
          produce = 1'b1;
          op      = OP_ARM;
        end
        default: produce = 1'b0;
      endcase
    end
  end

  assign q_push      = accept && produce;
  assign q_cmd.op    = op;
  assign q_cmd.data  = in_rx_byte;
  assign q_cmd.crc   = crc_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_TID1;
      length_high_r  <= 8'd0;
      frame_length_r <= 8'd0;
      count_r        <= 8'd0;
      crc_r          <= CRC_INIT;
      proto_bad_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      length_high_r  <= length_high_nxt;
      frame_length_r <= frame_length_nxt;
      count_r        <= count_nxt;
      crc_r          <= crc_nxt;
      proto_bad_r    <= proto_bad_nxt;
    end
  end

  // a restart always returns the parser to the header start
  a_restart_home: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_kind) |=> (phase_r == PH_TID1 && crc_r == CRC_INIT))
    else $error("restart did not reset parser");

  // payload phases only ever follow an accepted length
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_UNIT) |-> (frame_length_r >= 8'd2 && frame_length_r <= 8'(MAX_LENGTH)))
    else $error("frame length out of range in payload");

  // a frame-end command leaves the parser waiting
  a_end_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_cmd.op == OP_FWD_END) |=> (phase_r == PH_WAIT))
    else $error("frame end without wait");

endmodule
`default_nettype wire

// ===== design/mtrb_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mtrb_fifo
// Short command queue between the parser and the serial result sequencer.
// ---------------------------------------------------------------------------
module mtrb_fifo #(
  parameter int DEPTH = mtrb_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire mtrb_pkg::cmd_t wr_data,
  output logic                full,
  input  wire logic           pop,
  output mtrb_pkg::cmd_t      rd_data,
  output logic                empty
);
  import mtrb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count lost a transaction");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== design/mtrb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mtrb_back
// Expands queued commands into serial results, one per accepted transaction.
// ---------------------------------------------------------------------------
module mtrb_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire mtrb_pkg::cmd_t q_cmd,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                out_waiting
);
  import mtrb_pkg::*;

  logic       cur_valid_r, cur_valid_nxt;
  cmd_t       cur_r, cur_nxt;
  logic [2:0] idx_r, idx_nxt;

  logic       out_accept;
  logic       at_end;
  logic       load;
  out_kind_t  kind_sel;
  logic [7:0] byte_sel;

  assign out_accept = cur_valid_r && !out_stall;
  assign at_end     = (cur_r.op != OP_FWD_END) || (idx_r == BURST_LAST);
  assign load       = !q_empty && (!cur_valid_r || (out_accept && at_end));
  assign q_pop      = load;

  // next state
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    if (load) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = q_cmd;
      idx_nxt       = 3'd0;
    end else if (out_accept) begin
      if (at_end) begin
        cur_valid_nxt = 1'b0;
        idx_nxt       = 3'd0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  // result fields
  always_comb begin
    kind_sel = OK_SERIAL;
    byte_sel = 8'd0;
    case (idx_r)
      3'd0: begin
        case (cur_r.op)
          OP_ARM:   kind_sel = OK_ARM;
          OP_ABORT: kind_sel = OK_ABORT;
          default: begin
            kind_sel = OK_SERIAL;
            byte_sel = cur_r.data;
          end
        endcase
      end
      3'd1:    byte_sel = cur_r.crc[7:0];
      3'd2:    byte_sel = cur_r.crc[15:8];
      3'd3:    kind_sel = OK_START;
      default: kind_sel = OK_ARM;
    endcase
  end

  assign out_valid   = cur_valid_r;
  assign out_kind    = kind_sel;
  assign out_byte    = byte_sel;
  assign out_last    = at_end;
  assign out_waiting = (cur_r.op == OP_FWD_END) || (cur_r.op == OP_ARM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  a_single_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && cur_r.op != OP_FWD_END) |-> (idx_r == 3'd0))
    else $error("single-result command past first result");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= BURST_LAST)
    else $error("burst index out of range");

  a_burst_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_accept && !at_end) |=> (cur_valid_r && idx_r == $past(idx_r) + 3'd1))
    else $error("burst did not advance");

endmodule
`default_nettype wire

// ===== design/modbus_tcp_to_rtu_bridge_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// modbus_tcp_to_rtu_bridge_unit
// Modbus tcp byte stream in, rtu serial results out.
//
// Input channel (in_valid/in_stall): one tcp byte or a restart per
// transaction. Result channel (out_valid/out_stall): one result per
// transaction, out_last marks the final result of an input item.
// Header bytes, drops and idle restarts yield no result. A payload byte
// yields one serial byte; the last payload byte yields five results (the
// byte, crc low, crc high, rtu start, timer arm).
// An accepted input is registered in the command queue, then in cur_r.
// Throughput: one input per cycle unless in_stall; results leave at
// one per cycle unless out_stall, so a frame end occupies the result side
// for five results while the command queue (FIFO_DEPTH entries) keeps
// taking input. in_stall rises only when the command queue is full.
// A stalled result holds its fields until taken.
// Reset (rst_n low, synchronous) returns the parser to the header start,
// loads the crc with 0xffff and empties the queue.
// ---------------------------------------------------------------------------
module modbus_tcp_to_rtu_bridge_unit #(
  parameter int MAX_LENGTH = mtrb_pkg::MAX_LENGTH_DEF,
  parameter int FIFO_DEPTH = mtrb_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_waiting
);
  import mtrb_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, pop, q_full, q_empty;

  mtrb_front #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .in_rx_byte(in_rx_byte),
    .q_full    (q_full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  mtrb_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_data(push_cmd),
    .full   (q_full),
    .pop    (pop),
    .rd_data(pop_cmd),
    .empty  (q_empty)
  );

  mtrb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_cmd      (pop_cmd),
    .q_empty    (q_empty),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_waiting(out_waiting)
  );

endmodule
`default_nettype wire
